>>> src/edsp_pkg.sv
// shared types, codes and the operation sequence table of the escaped display stream parser
package edsp_pkg;

  localparam logic [7:0] ESCAPE_CODE     = 8'hAA;
  localparam logic [7:0] ESC_ESCAPE_CODE = 8'hA9;
  localparam logic [7:0] START_CODE      = 8'hA0;
  localparam logic [7:0] CMD_AUTO_OFF    = 8'hB2;
  localparam logic [7:0] CMD_AUTO_WRITE  = 8'hB0;
  localparam logic [7:0] CMD_SET_ADDRESS = 8'h24;
  localparam logic [7:0] START_ADDR_LOW  = 8'h00;
  localparam logic [7:0] START_ADDR_HIGH = 8'h08;
  localparam logic [7:0] BRIGHT_LIMIT_RST = 8'd100;

  localparam int unsigned StepW = 2;

  typedef enum logic [1:0] {
    MODE_ESCAPE     = 2'd0,
    MODE_BRIGHTNESS = 2'd1,
    MODE_WRITE      = 2'd2,
    MODE_ERROR      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_COMMAND = 2'd1,
    OP_BRIGHT  = 2'd2
  } op_kind_e;

  typedef enum logic [1:0] {
    JOB_DATA   = 2'd0,
    JOB_START  = 2'd1,
    JOB_BRIGHT = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] value;
  } job_t;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] value;
    logic       last;
  } op_t;

  // operation number step of a job
  function automatic op_t job_op(input job_t job, input logic [StepW-1:0] step);
    op_t op;
    op.kind  = OP_DATA;
    op.value = job.value;
    op.last  = 1'b1;
    case (job.kind)
      JOB_START: begin
        op.last = (step == 2'd3);
        case (step)
          2'd0: begin
            op.kind  = OP_COMMAND;
            op.value = CMD_AUTO_OFF;
          end
          2'd1: begin
            op.kind  = OP_DATA;
            op.value = START_ADDR_LOW;
          end
          2'd2: begin
            op.kind  = OP_DATA;
            op.value = START_ADDR_HIGH;
          end
          default: begin
            op.kind  = OP_COMMAND;
            op.value = CMD_SET_ADDRESS;
          end
        endcase
      end
      JOB_BRIGHT: begin
        op.last = (step == 2'd1);
        if (step == 2'd0) begin
          op.kind  = OP_BRIGHT;
          op.value = job.value;
        end else begin
          op.kind  = OP_COMMAND;
          op.value = CMD_AUTO_WRITE;
        end
      end
      default: begin
        op.kind  = OP_DATA;
        op.value = job.value;
        op.last  = 1'b1;
      end
    endcase
    return op;
  endfunction

endpackage

>>> src/escaped_display_stream_parser_unit.sv
// top level of the escaped display stream parser
// the first bus operation of a byte passes through the job queue and then into the output register
// one bus operation per cycle while jobs wait and the output is not stalled; a byte gives one to four
// operations (start sequence four, brightness two, data one, bytes without operations none)
// the job queue lets bytes keep arriving while the sequencer works through a start sequence
// reset: mode goes to error, brightness limit to 100, queue and output register empty
module escaped_display_stream_parser_unit
  import edsp_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  output logic [1:0] op_kind_o,
  output logic [7:0] op_value_o,
  output logic       last_op_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  edsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_job_o (push_job)
  );

  edsp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_job_i(push_job),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (head_job)
  );

  edsp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (head_job),
    .pop_o      (q_pop),
    .op_kind_o  (op_kind_o),
    .op_value_o (op_value_o),
    .last_op_o  (last_op_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

endmodule

>>> src/edsp_front.sv
// front end: mode tracking, byte classification and the brightness limit register
module edsp_front
  import edsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       push_job_o
);

  mode_e      mode_q, mode_d;
  logic [7:0] limit_q;
  logic       accept;

  assign in_stall_o  = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ERROR;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= BRIGHT_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  always_comb begin
    mode_d           = mode_q;
    push_o           = 1'b0;
    push_job_o.kind  = JOB_DATA;
    push_job_o.value = rx_byte_i;
    if (accept) begin
      if (rx_byte_i == ESCAPE_CODE) begin
        mode_d = MODE_ESCAPE;
      end else begin
        case (mode_q)
          MODE_ESCAPE: begin
            if (rx_byte_i == ESC_ESCAPE_CODE) begin
              push_o           = 1'b1;
              push_job_o.kind  = JOB_DATA;
              push_job_o.value = ESCAPE_CODE;
              mode_d           = MODE_WRITE;
            end else if (rx_byte_i == START_CODE) begin
              push_o          = 1'b1;
              push_job_o.kind = JOB_START;
              mode_d          = MODE_BRIGHTNESS;
            end else begin
              mode_d = MODE_ERROR;
            end
          end
          MODE_BRIGHTNESS: begin
            if (rx_byte_i <= limit_q) begin
              push_o          = 1'b1;
              push_job_o.kind = JOB_BRIGHT;
              mode_d          = MODE_WRITE;
            end else begin
              mode_d = MODE_ERROR;
            end
          end
          MODE_WRITE: begin
            push_o = 1'b1;
          end
          default: begin
            mode_d = MODE_ERROR;
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_escape_enters_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rx_byte_i == ESCAPE_CODE |=> mode_q == MODE_ESCAPE)
    else $error("escape byte did not enter escape mode");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept && !q_full_i)
    else $error("job pushed without a transfer or into a full queue");
`endif

endmodule

>>> src/edsp_queue.sv
// short job queue between the front and back ends
module edsp_queue
  import edsp_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");
`endif

endmodule

>>> src/edsp_back.sv
// back end: steps through each job's bus operations into the output register
module edsp_back
  import edsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       q_head_i,
  output logic       pop_o,
  output logic [1:0] op_kind_o,
  output logic [7:0] op_value_o,
  output logic       last_op_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic             busy_q, busy_d;
  job_t             job_q, job_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  op_t              out_q, out_d;
  job_t             src_job;
  logic [StepW-1:0] src_step;
  logic             src_valid;
  logic             load;
  op_t              op;

  assign src_job   = busy_q ? job_q : q_head_i;
  assign src_step  = busy_q ? step_q : '0;
  assign src_valid = busy_q || q_valid_i;
  assign load      = !out_valid_q || !out_stall_i;
  assign op        = job_op(src_job, src_step);

  always_comb begin
    busy_d      = busy_q;
    job_d       = job_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = src_valid;
      out_d       = op;
      if (src_valid) begin
        pop_o = !busy_q;
        if (op.last) begin
          busy_d = 1'b0;
          step_d = '0;
        end else begin
          busy_d = 1'b1;
          job_d  = src_job;
          step_d = src_step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign op_kind_o   = out_q.kind;
  assign op_value_o  = out_q.value;
  assign last_op_o   = out_q.last;

`ifndef NO_ASSERTIONS
  a_busy_multi_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> job_q.kind != JOB_DATA && step_q != '0)
    else $error("sequencer busy on a single operation job");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy_q && q_valid_i)
    else $error("queue popped while a job is in progress");
`endif

endmodule

>>> tb/escaped_display_stream_parser_unit_tb.sv
// testbench of the escaped display stream parser: predicted bus operations checked in order
`timescale 1ns / 1ps

module escaped_display_stream_parser_unit_tb;
  import edsp_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned SettleTicks = 16;
  localparam int unsigned PhaseBytes  = 36;

  class display_op_tracker;
    mode_e       mode;
    logic [7:0]  limit;
    op_t         pending_ops[$];
    int unsigned err_count;

    function new();
      mode      = MODE_ERROR;
      limit     = BRIGHT_LIMIT_RST;
      err_count = 0;
    endfunction

    function void set_limit(input logic [7:0] v);
      limit = v;
    endfunction

    function void push_op(input op_kind_e kind, input logic [7:0] value, input logic last);
      op_t op;
      op.kind  = kind;
      op.value = value;
      op.last  = last;
      pending_ops.push_back(op);
    endfunction

    function void take_byte(input logic [7:0] b);
      if (b == ESCAPE_CODE) begin
        mode = MODE_ESCAPE;
        return;
      end
      case (mode)
        MODE_ESCAPE: begin
          if (b == ESC_ESCAPE_CODE) begin
            push_op(OP_DATA, ESCAPE_CODE, 1'b1);
            mode = MODE_WRITE;
          end else if (b == START_CODE) begin
            push_op(OP_COMMAND, CMD_AUTO_OFF, 1'b0);
            push_op(OP_DATA, START_ADDR_LOW, 1'b0);
            push_op(OP_DATA, START_ADDR_HIGH, 1'b0);
            push_op(OP_COMMAND, CMD_SET_ADDRESS, 1'b1);
            mode = MODE_BRIGHTNESS;
          end else begin
            mode = MODE_ERROR;
          end
        end
        MODE_BRIGHTNESS: begin
          if (b <= limit) begin
            push_op(OP_BRIGHT, b, 1'b0);
            push_op(OP_COMMAND, CMD_AUTO_WRITE, 1'b1);
            mode = MODE_WRITE;
          end else begin
            mode = MODE_ERROR;
          end
        end
        MODE_WRITE: begin
          push_op(OP_DATA, b, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_op(input logic [1:0] kind, input logic [7:0] value, input logic last);
      op_t want;
      if (pending_ops.size() == 0) begin
        $error("unexpected bus op: op_kind %0d op_value 0x%02h last_op %0b", kind, value, last);
        err_count++;
        return;
      end
      want = pending_ops.pop_front();
      if (kind !== want.kind) begin
        $error("op_kind mismatch: expected %0d, actual %0d", want.kind, kind);
        err_count++;
      end
      if (value !== want.value) begin
        $error("op_value mismatch: expected 0x%02h, actual 0x%02h", want.value, value);
        err_count++;
      end
      if (last !== want.last) begin
        $error("last_op mismatch: expected %0b, actual %0b", want.last, last);
        err_count++;
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = 8'h00;
  logic [1:0] op_kind_o;
  logic [7:0] op_value_o;
  logic       last_op_o;
  logic       out_valid_o;
  logic       out_stall_i = 1'b1;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  display_op_tracker ops_tracker = new();

  logic [7:0] directed_bytes [25] = '{
    8'h55, START_CODE, ESCAPE_CODE, START_CODE, BRIGHT_LIMIT_RST,
    8'h00, 8'hFF, ESC_ESCAPE_CODE, START_CODE, ESCAPE_CODE,
    ESC_ESCAPE_CODE, ESCAPE_CODE, ESCAPE_CODE, 8'h12, ESCAPE_CODE,
    START_CODE, BRIGHT_LIMIT_RST + 8'd1, 8'h77, ESCAPE_CODE, START_CODE,
    8'h00, ESCAPE_CODE, START_CODE, ESCAPE_CODE, ESC_ESCAPE_CODE
  };

  escaped_display_stream_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .op_kind_o  (op_kind_o),
    .op_value_o (op_value_o),
    .last_op_o  (last_op_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      ops_tracker.check_op(op_kind_o, op_value_o, last_op_o);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("escaped_display_stream_parser_unit verification failed");
    $finish;
  end

  // called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ops_tracker.take_byte(b);
    @(negedge clk_i);
  endtask

  task automatic drain_ops();
    in_valid_i <= 1'b0;
    while (ops_tracker.pending_ops.size() != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain_ops();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    ops_tracker.set_limit(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random_stream(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int          lim;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // frame: start, brightness, escaped payload
        send_byte(ESCAPE_CODE);
        send_byte(START_CODE);
        lim = int'(ops_tracker.limit);
        if ($urandom_range(9) != 0 || lim == 255) begin
          b = 8'($urandom_range(lim, 0));
        end else begin
          b = 8'($urandom_range(255, lim + 1));
        end
        send_byte(b);
        sent += 3;
        len = $urandom_range(8);
        repeat (len) begin
          b = 8'($urandom);
          if (b == ESCAPE_CODE) begin
            send_byte(ESCAPE_CODE);
            b = ESC_ESCAPE_CODE;
            sent++;
          end
          send_byte(b);
          sent++;
        end
      end else if (pick < 85) begin
        send_byte(ESCAPE_CODE);
        send_byte(8'($urandom));
        sent += 2;
      end else begin
        send_byte(8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i]);
    end

    write_limit(8'd0);
    send_random_stream(PhaseBytes);

    write_limit(8'd255);
    send_idle_pct = 73;
    send_random_stream(PhaseBytes);

    write_limit(8'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    send_random_stream(PhaseBytes);

    write_limit(BRIGHT_LIMIT_RST);
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    send_random_stream(PhaseBytes);

    write_limit(8'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_stream(PhaseBytes);

    drain_ops();
    if (ops_tracker.pending_ops.size() != 0) begin
      $error("bus ops never seen: %0d", ops_tracker.pending_ops.size());
      ops_tracker.err_count++;
    end
    if (ops_tracker.err_count == 0) begin
      $display("escaped_display_stream_parser_unit verification clean");
    end else begin
      $display("escaped_display_stream_parser_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/edsp_pkg.sv
src/edsp_front.sv
src/edsp_queue.sv
src/edsp_back.sv
src/escaped_display_stream_parser_unit.sv
tb/escaped_display_stream_parser_unit_tb.sv
